@@ rtl/core/iors_pkg.sv @@
// iors_pkg: shared types and codes of the disk request scheduler.
// Item structs, op/status/policy codes, field widths. No dependencies.
package iors_pkg;

  localparam int SectorW = 64;
  localparam int LengthW = 32;
  localparam int StampW  = 32;
  localparam int HandleW = 4;
  localparam int SlotW   = 4;
  localparam int PendW   = 5;
  localparam int WordW   = 64;
  localparam int OpW     = 2;
  localparam int StatusW = 2;
  localparam int PolicyW = 2;

  // op codes
  localparam logic [OpW-1:0] OP_ADD      = 2'd0;
  localparam logic [OpW-1:0] OP_QUERY    = 2'd1;
  localparam logic [OpW-1:0] OP_COMPLETE = 2'd2;

  // status codes
  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY     = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd2;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd3;

  // policy codes (anything else runs as fifo)
  localparam logic [PolicyW-1:0] POL_FIFO     = 2'd0;
  localparam logic [PolicyW-1:0] POL_DEADLINE = 2'd1;
  localparam logic [PolicyW-1:0] POL_NEAREST  = 2'd2;

  typedef struct packed {
    logic [OpW-1:0]     op;
    logic [SectorW-1:0] sector;
    logic [LengthW-1:0] length;
    logic               direction;
    logic [StampW-1:0]  timestamp;
    logic [HandleW-1:0] handle;
  } iors_in_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   slot;
    logic [SectorW-1:0] picked_sector;
    logic [LengthW-1:0] picked_length;
    logic               picked_direction;
    logic [PendW-1:0]   pending;
    logic [WordW-1:0]   head_position;
    logic [WordW-1:0]   requests_total;
    logic [WordW-1:0]   sectors_total;
    logic [WordW-1:0]   latency_sum;
  } iors_out_t;

  // read/write strobes of the two table memories
  typedef struct packed {
    logic ent_re;
    logic ent_we;
    logic ord_re;
    logic ord_we;
  } iors_mem_ctl_t;

endpackage

@@ rtl/core/io_request_scheduler.sv @@
// io_request_scheduler: top level of the pending disk request table.
// Depends on iors_pkg, iors_alu and iors_store.
//
// Keeps up to QUEUE_DEPTH disk requests in a slot table plus a list that
// orders them, and handles one item at a time: add a request (fifo append,
// reads-first for the deadline policy, sector-sorted insert for the nearest
// policy), query the next request (list head, oldest timestamp, or nearest
// sector to the head position; ties go to the earlier list entry), or
// complete a request by slot, which moves the head to sector + length and
// adds its latency to a running sum. Every item gives one result item.
// in_stall_o is high from acceptance until the result has been loaded into
// the output register; a result may wait there while the next item is
// taken. All word arithmetic goes through one 64-bit add/subtract unit, and
// the list lives in a single-port-read memory, so the cost of an item is set
// by its list walks, which read one list entry at a time. Steps per item:
//   add:      scan for the lowest free slot, for the nearest policy walk
//             the sorted list comparing sectors, move later entries up, write
//   query:    walk every entry (deadline, nearest) or take the list head (fifo)
//   complete: find the slot in the list, move the entries after it down,
//             then add the latency and move the head
//   rejected adds, empty queries, unknown handles, unused op: no walk
// The table state comes out of reset ready; there is no clearing pass. The
// policy register may only be written while the block is idle.
module io_request_scheduler import iors_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  iors_in_t           in_data_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output iors_out_t          out_data_o,
  // policy register write
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [PolicyW-1:0] cfg_data_i
);

  localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int TimeW = (TIME_BITS < StampW) ? TIME_BITS : StampW;
  localparam int EntW  = 1 + LengthW + SectorW + TimeW;
  localparam int XW    = ((AW > HandleW) ? AW : HandleW) + 1;
  localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);
  localparam logic [XW-1:0] DepthX = XW'(QUEUE_DEPTH);

  // sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_FREE    = 5'd1;   // scan for lowest free slot
  localparam logic [4:0] S_A_RDORD = 5'd2;   // sorted insert walk
  localparam logic [4:0] S_A_RDENT = 5'd3;
  localparam logic [4:0] S_A_CMP   = 5'd4;
  localparam logic [4:0] S_SH_RD   = 5'd5;   // open a gap in the list
  localparam logic [4:0] S_SH_WR   = 5'd6;
  localparam logic [4:0] S_A_WRITE = 5'd7;
  localparam logic [4:0] S_A_CNT   = 5'd8;
  localparam logic [4:0] S_Q_RDORD = 5'd9;   // selection walk
  localparam logic [4:0] S_Q_RDENT = 5'd10;
  localparam logic [4:0] S_Q_EVAL  = 5'd11;
  localparam logic [4:0] S_Q_ABS   = 5'd12;
  localparam logic [4:0] S_Q_CMP   = 5'd13;
  localparam logic [4:0] S_Q_FETCH = 5'd14;
  localparam logic [4:0] S_C_RDORD = 5'd15;  // find handle in the list
  localparam logic [4:0] S_C_CMP   = 5'd16;
  localparam logic [4:0] S_R_RD    = 5'd17;  // close the gap
  localparam logic [4:0] S_R_WR    = 5'd18;
  localparam logic [4:0] S_C_RDENT = 5'd19;
  localparam logic [4:0] S_C_LAT1  = 5'd20;
  localparam logic [4:0] S_C_LAT2  = 5'd21;
  localparam logic [4:0] S_C_HEAD  = 5'd22;
  localparam logic [4:0] S_RESP    = 5'd23;

  // control state
  logic [4:0]             state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [QUEUE_DEPTH-1:0] valid_q, valid_d;
  logic [PolicyW-1:0]     policy_q, policy_d;
  logic                   out_valid_q, out_valid_d;
  logic [WordW-1:0]       head_q, head_d;
  logic [WordW-1:0]       acc_q, acc_d;
  logic [WordW-1:0]       ssum_q, ssum_d;
  logic [WordW-1:0]       lat_q, lat_d;

  // working registers
  logic [CW-1:0]          idx_q, idx_d;
  logic [CW-1:0]          pos_q, pos_d;
  logic [AW-1:0]          slot_q, slot_d;
  logic [AW-1:0]          best_q, best_d;
  logic [WordW-1:0]       key_q, key_d;
  logic [WordW-1:0]       tmp_q, tmp_d;
  logic                   neg_q, neg_d;
  iors_in_t               item_q, item_d;
  logic [StatusW-1:0]     res_status_q, res_status_d;
  logic [AW-1:0]          res_slot_q, res_slot_d;
  logic                   res_pick_q, res_pick_d;
  iors_out_t              out_q, out_d;

  // memory and ALU hookup
  iors_mem_ctl_t          mem_ctl;
  logic [AW-1:0]          ent_waddr, ent_raddr, ord_waddr, ord_raddr, ord_wdata, ord_rdata;
  logic [EntW-1:0]        ent_wdata, ent_rdata;
  logic [WordW-1:0]       alu_a, alu_b, alu_res;
  logic                   alu_sub, alu_carry, alu_lt;

  logic                   in_acc;
  logic [CW-1:0]          idx_inc, idx_dec;
  logic [XW-1:0]          in_hx, item_hx;
  logic [AW-1:0]          in_ha, item_ha;
  logic                   in_hit;
  logic [TimeW-1:0]       ent_time;
  logic [SectorW-1:0]     ent_sector;
  logic [LengthW-1:0]     ent_len;
  logic                   ent_dir;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign idx_inc = idx_q + 1'b1;
  assign idx_dec = idx_q - 1'b1;

  // handle range check: handles at or above the depth name no slot
  assign in_hx   = XW'(in_data_i.handle);
  assign in_ha   = in_hx[AW-1:0];
  assign in_hit  = (in_hx < DepthX) && valid_q[in_ha];
  assign item_hx = XW'(item_q.handle);
  assign item_ha = item_hx[AW-1:0];

  // entry word: {direction, length, sector, time}
  assign ent_time   = ent_rdata[TimeW-1:0];
  assign ent_sector = ent_rdata[TimeW +: SectorW];
  assign ent_len    = ent_rdata[TimeW + SectorW +: LengthW];
  assign ent_dir    = ent_rdata[EntW-1];
  assign ent_wdata  = {item_q.direction, item_q.length, item_q.sector,
                       item_q.timestamp[TimeW-1:0]};
  assign ent_waddr  = slot_q;
  assign ord_waddr  = (state_q == S_A_WRITE) ? pos_q[AW-1:0] : idx_q[AW-1:0];
  assign ord_wdata  = (state_q == S_A_WRITE) ? slot_q : ord_rdata;

  assign alu_lt = ~alu_carry;

  iors_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  iors_store #(
    .Depth (QUEUE_DEPTH),
    .AddrW (AW),
    .EntW  (EntW)
  ) u_store (
    .clk_i       (clk_i),
    .ctl_i       (mem_ctl),
    .ent_waddr_i (ent_waddr),
    .ent_wdata_i (ent_wdata),
    .ent_raddr_i (ent_raddr),
    .ent_rdata_o (ent_rdata),
    .ord_waddr_i (ord_waddr),
    .ord_wdata_i (ord_wdata),
    .ord_raddr_i (ord_raddr),
    .ord_rdata_o (ord_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    valid_d      = valid_q;
    head_d       = head_q;
    acc_d        = acc_q;
    ssum_d       = ssum_q;
    lat_d        = lat_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    slot_d       = slot_q;
    best_d       = best_q;
    key_d        = key_q;
    tmp_d        = tmp_q;
    neg_d        = neg_q;
    item_d       = item_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_pick_d   = res_pick_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    policy_d     = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : policy_q;
    mem_ctl      = '0;
    ent_raddr    = '0;
    ord_raddr    = '0;
    alu_a        = '0;
    alu_b        = '0;
    alu_sub      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          item_d       = in_data_i;
          idx_d        = '0;
          res_status_d = ST_OK;
          res_slot_d   = '0;
          res_pick_d   = 1'b0;
          case (in_data_i.op)
            OP_ADD: begin
              if (count_q == DepthC) begin
                res_status_d = ST_FULL;
                state_d      = S_RESP;
              end else begin
                state_d = S_FREE;
              end
            end
            OP_QUERY: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
                state_d      = S_RESP;
              end else begin
                state_d = S_Q_RDORD;
              end
            end
            OP_COMPLETE: begin
              if (!in_hit) begin
                res_status_d = ST_NOT_FOUND;
                state_d      = S_RESP;
              end else begin
                state_d = S_C_RDORD;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      // add: lowest free slot, one valid bit per cycle
      S_FREE: begin
        if (!valid_q[idx_q[AW-1:0]]) begin
          slot_d = idx_q[AW-1:0];
          if (policy_q == POL_NEAREST && count_q != '0) begin
            idx_d   = '0;
            state_d = S_A_RDORD;
          end else begin
            if (policy_q == POL_DEADLINE && !item_q.direction) begin
              pos_d = '0;
            end else begin
              pos_d = count_q;
            end
            idx_d   = count_q;
            state_d = S_SH_RD;
          end
        end else begin
          idx_d = idx_inc;
        end
      end

      S_A_RDORD: begin
        mem_ctl.ord_re = 1'b1;
        ord_raddr      = idx_q[AW-1:0];
        state_d        = S_A_RDENT;
      end

      S_A_RDENT: begin
        mem_ctl.ent_re = 1'b1;
        ent_raddr      = ord_rdata;
        state_d        = S_A_CMP;
      end

      // new request goes before the first entry whose sector is not smaller
      S_A_CMP: begin
        alu_a   = ent_sector;
        alu_b   = item_q.sector;
        alu_sub = 1'b1;
        if (alu_lt && idx_inc != count_q) begin
          idx_d   = idx_inc;
          state_d = S_A_RDORD;
        end else begin
          pos_d   = alu_lt ? count_q : idx_q;
          idx_d   = count_q;
          state_d = S_SH_RD;
        end
      end

      // move entries pos..count-1 up by one, top first
      S_SH_RD: begin
        if (idx_q == pos_q) begin
          state_d = S_A_WRITE;
        end else begin
          mem_ctl.ord_re = 1'b1;
          ord_raddr      = idx_dec[AW-1:0];
          state_d        = S_SH_WR;
        end
      end

      S_SH_WR: begin
        mem_ctl.ord_we = 1'b1;
        idx_d          = idx_dec;
        state_d        = S_SH_RD;
      end

      S_A_WRITE: begin
        mem_ctl.ord_we  = 1'b1;
        mem_ctl.ent_we  = 1'b1;
        valid_d[slot_q] = 1'b1;
        count_d         = count_q + 1'b1;
        alu_a           = ssum_q;
        alu_b           = WordW'(item_q.length);
        ssum_d          = alu_res;
        res_slot_d      = slot_q;
        state_d         = S_A_CNT;
      end

      S_A_CNT: begin
        alu_a   = acc_q;
        alu_b   = WordW'(1);
        acc_d   = alu_res;
        state_d = S_RESP;
      end

      // query: walk the list (fifo stops at the head), keep the best slot and its key
      S_Q_RDORD: begin
        mem_ctl.ord_re = 1'b1;
        ord_raddr      = idx_q[AW-1:0];
        state_d        = S_Q_RDENT;
      end

      S_Q_RDENT: begin
        mem_ctl.ent_re = 1'b1;
        ent_raddr      = ord_rdata;
        state_d        = S_Q_EVAL;
      end

      S_Q_EVAL: begin
        case (policy_q)
          POL_NEAREST: begin
            alu_a   = ent_sector;
            alu_b   = head_q;
            alu_sub = 1'b1;
            tmp_d   = alu_res;
            neg_d   = alu_lt;
            state_d = S_Q_ABS;
          end
          POL_DEADLINE: begin
            tmp_d   = WordW'(ent_time);
            state_d = S_Q_CMP;
          end
          default: begin
            best_d  = ord_rdata;
            state_d = S_Q_FETCH;
          end
        endcase
      end

      // distance = |sector - head|: negate when the difference borrowed
      S_Q_ABS: begin
        alu_a   = neg_q ? '0 : tmp_q;
        alu_b   = neg_q ? tmp_q : '0;
        alu_sub = 1'b1;
        tmp_d   = alu_res;
        state_d = S_Q_CMP;
      end

      // strict less-than keeps the earlier entry on ties
      S_Q_CMP: begin
        alu_a   = tmp_q;
        alu_b   = key_q;
        alu_sub = 1'b1;
        if (idx_q == '0 || alu_lt) begin
          best_d = ord_rdata;
          key_d  = tmp_q;
        end
        if (idx_inc == count_q) begin
          state_d = S_Q_FETCH;
        end else begin
          idx_d   = idx_inc;
          state_d = S_Q_RDORD;
        end
      end

      S_Q_FETCH: begin
        mem_ctl.ent_re = 1'b1;
        ent_raddr      = best_q;
        res_slot_d     = best_q;
        res_pick_d     = 1'b1;
        state_d        = S_RESP;
      end

      // complete: locate the handle's list position
      S_C_RDORD: begin
        mem_ctl.ord_re = 1'b1;
        ord_raddr      = idx_q[AW-1:0];
        state_d        = S_C_CMP;
      end

      S_C_CMP: begin
        if (ord_rdata == item_ha) begin
          state_d = S_R_RD;
        end else begin
          idx_d   = idx_inc;
          state_d = S_C_RDORD;
        end
      end

      // move entries after it down by one
      S_R_RD: begin
        if (idx_inc == count_q) begin
          state_d = S_C_RDENT;
        end else begin
          mem_ctl.ord_re = 1'b1;
          ord_raddr      = idx_inc[AW-1:0];
          state_d        = S_R_WR;
        end
      end

      S_R_WR: begin
        mem_ctl.ord_we = 1'b1;
        idx_d          = idx_inc;
        state_d        = S_R_RD;
      end

      S_C_RDENT: begin
        mem_ctl.ent_re = 1'b1;
        ent_raddr      = item_ha;
        state_d        = S_C_LAT1;
      end

      S_C_LAT1: begin
        alu_a   = WordW'(item_q.timestamp[TimeW-1:0]);
        alu_b   = WordW'(ent_time);
        alu_sub = 1'b1;
        tmp_d   = alu_res;
        state_d = S_C_LAT2;
      end

      S_C_LAT2: begin
        alu_a   = lat_q;
        alu_b   = tmp_q;
        lat_d   = alu_res;
        state_d = S_C_HEAD;
      end

      S_C_HEAD: begin
        alu_a            = ent_sector;
        alu_b            = WordW'(ent_len);
        head_d           = alu_res;
        valid_d[item_ha] = 1'b0;
        count_d          = count_q - 1'b1;
        res_slot_d       = item_ha;
        res_pick_d       = 1'b1;
        state_d          = S_RESP;
      end

      // load the output register once it is free
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          out_d.status           = res_status_q;
          out_d.slot             = SlotW'(res_slot_q);
          out_d.picked_sector    = res_pick_q ? ent_sector : '0;
          out_d.picked_length    = res_pick_q ? ent_len : '0;
          out_d.picked_direction = res_pick_q && ent_dir;
          out_d.pending          = PendW'(count_q);
          out_d.head_position    = head_q;
          out_d.requests_total   = acc_q;
          out_d.sectors_total    = ssum_q;
          out_d.latency_sum      = lat_q;
          state_d                = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      valid_q     <= '0;
      policy_q    <= POL_FIFO;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      acc_q       <= '0;
      ssum_q      <= '0;
      lat_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      valid_q     <= valid_d;
      policy_q    <= policy_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      acc_q       <= acc_d;
      ssum_q      <= ssum_d;
      lat_q       <= lat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    slot_q       <= slot_d;
    best_q       <= best_d;
    key_q        <= key_d;
    tmp_q        <= tmp_d;
    neg_q        <= neg_d;
    item_q       <= item_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_pick_q   <= res_pick_d;
    out_q        <= out_d;
  end

endmodule

@@ rtl/core/iors_alu.sv @@
// iors_alu: the one shared 64-bit add/subtract unit of the scheduler.
// Depends on iors_pkg for the word width.
module iors_alu import iors_pkg::*; (
  input  logic [WordW-1:0] a_i,
  input  logic [WordW-1:0] b_i,
  input  logic             sub_i,
  output logic [WordW-1:0] res_o,
  output logic             carry_o
);

  logic [WordW-1:0] b_op;

  assign b_op = sub_i ? ~b_i : b_i;
  // carry out low on a subtract means a < b
  assign {carry_o, res_o} = {1'b0, a_i} + {1'b0, b_op} + {{WordW{1'b0}}, sub_i};

endmodule

@@ rtl/core/iors_store.sv @@
// iors_store: request entry memory (by slot) and list order memory (by position).
// Depends on iors_pkg for the strobe struct. Read data registered, held between reads.
module iors_store import iors_pkg::*; #(
  parameter int Depth = 16,
  parameter int AddrW = 4,
  parameter int EntW  = 129
) (
  input  logic              clk_i,
  input  iors_mem_ctl_t     ctl_i,
  input  logic [AddrW-1:0]  ent_waddr_i,
  input  logic [EntW-1:0]   ent_wdata_i,
  input  logic [AddrW-1:0]  ent_raddr_i,
  output logic [EntW-1:0]   ent_rdata_o,
  input  logic [AddrW-1:0]  ord_waddr_i,
  input  logic [AddrW-1:0]  ord_wdata_i,
  input  logic [AddrW-1:0]  ord_raddr_i,
  output logic [AddrW-1:0]  ord_rdata_o
);

  logic [EntW-1:0]  ent_mem [Depth];
  logic [AddrW-1:0] ord_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (ctl_i.ent_we) begin
      ent_mem[ent_waddr_i] <= ent_wdata_i;
    end
    if (ctl_i.ent_re) begin
      ent_rdata_o <= ent_mem[ent_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ord_we) begin
      ord_mem[ord_waddr_i] <= ord_wdata_i;
    end
    if (ctl_i.ord_re) begin
      ord_rdata_o <= ord_mem[ord_raddr_i];
    end
  end

endmodule
